### rtl/bq_pkg.sv
// Package for the biquad filter: register map, APB widths and the control
// bundle that drives the bit-serial multiplier lanes.
// No dependencies.
package bq_pkg;

  // Coefficients are Q3.F: one sign bit and three integer bits above the fraction
  localparam int COEF_INT_BITS = 4;
  localparam int NUM_COEFS     = 5;
  localparam int COEF_IDX_BITS = $clog2(NUM_COEFS);
  localparam int APB_ADDR_BITS = COEF_IDX_BITS + 2;
  localparam int APB_DATA_BITS = 32;

  typedef enum logic [COEF_IDX_BITS-1:0] {
    IDX_B0 = 3'd0,
    IDX_B1 = 3'd1,
    IDX_B2 = 3'd2,
    IDX_A1 = 3'd3,
    IDX_A2 = 3'd4
  } coef_idx_e;

  // Control shared by all multiplier lanes
  typedef struct packed {
    logic load;  // clear the partial product
    logic step;  // consume one multiplier bit
    logic last;  // current bit is the sign bit
  } mul_ctrl_t;

endpackage

### rtl/bq_in_if.sv
// Input request channel of the biquad filter: one signed sample per request.
// No dependencies.
interface bq_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

### rtl/bq_out_if.sv
// Output request channel of the biquad filter: filtered sample and clip flag.
// No dependencies.
interface bq_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

### rtl/bq_ser_mul.sv
// Serial-parallel signed multiplier lane: parallel multiplicand, multiplier fed
// one bit per cycle LSB first while step is set. Depends on bq_pkg.
module bq_ser_mul
  import bq_pkg::*;
#(
  parameter int MCAND_BITS = 18,
  parameter int MPLR_BITS  = 16
) (
  input  logic                                 clk_i,
  input  mul_ctrl_t                            ctrl_i,
  input  logic signed [MCAND_BITS-1:0]         mcand_i,
  input  logic                                 mplr_bit_i,
  output logic signed [MCAND_BITS+MPLR_BITS-1:0] prod_o
);

  localparam int HI_BITS  = MCAND_BITS + 1;
  localparam int SUM_BITS = MCAND_BITS + 2;

  logic signed [HI_BITS-1:0]   hi_q, hi_d;
  logic        [MPLR_BITS-1:0] lo_q, lo_d;
  logic signed [SUM_BITS-1:0]  addend;
  logic signed [SUM_BITS-1:0]  sum;

  // Sign bit of the multiplier carries negative weight: subtract there
  always_comb begin
    addend = '0;
    if (mplr_bit_i) begin
      if (ctrl_i.last) begin
        addend = -SUM_BITS'(mcand_i);
      end else begin
        addend = SUM_BITS'(mcand_i);
      end
    end
    sum  = SUM_BITS'(hi_q) + addend;
    hi_d = sum[SUM_BITS-1:1];
    lo_d = {sum[0], lo_q[MPLR_BITS-1:1]};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      hi_q <= '0;
    end else if (ctrl_i.step) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign prod_o = {hi_q[MCAND_BITS-1:0], lo_q};

endmodule

### rtl/bq_coef_regs.sv
// APB register file for the five biquad coefficients.
// Depends on bq_pkg.
module bq_coef_regs
  import bq_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           psel,
  input  logic                                           penable,
  input  logic                                           pwrite,
  input  logic [APB_ADDR_BITS-1:0]                       paddr,
  input  logic [APB_DATA_BITS-1:0]                       pwdata,
  output logic [APB_DATA_BITS-1:0]                       prdata,
  output logic                                           pready,
  output logic signed [COEF_FRAC_BITS+COEF_INT_BITS-1:0] coef_o [NUM_COEFS]
);

  localparam int COEF_BITS = COEF_FRAC_BITS + COEF_INT_BITS;

  // Reset values 1, -2, 1, -0.2, 0.17 at the chosen fraction width
  localparam logic signed [COEF_BITS-1:0] RST_ONE  = COEF_BITS'(longint'(1) << COEF_FRAC_BITS);
  localparam logic signed [COEF_BITS-1:0] RST_B1   =
    COEF_BITS'(-(longint'(2) << COEF_FRAC_BITS));
  localparam logic signed [COEF_BITS-1:0] RST_A1   =
    COEF_BITS'(-$rtoi(0.2 * (2.0 ** COEF_FRAC_BITS) + 0.5));
  localparam logic signed [COEF_BITS-1:0] RST_A2   =
    COEF_BITS'($rtoi(0.17 * (2.0 ** COEF_FRAC_BITS) + 0.5));

  logic signed [COEF_BITS-1:0] coef_q [NUM_COEFS];
  coef_idx_e                   idx;
  logic                        wr_en;

  assign idx    = coef_idx_e'(paddr[APB_ADDR_BITS-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[IDX_B0] <= RST_ONE;
      coef_q[IDX_B1] <= RST_B1;
      coef_q[IDX_B2] <= RST_ONE;
      coef_q[IDX_A1] <= RST_A1;
      coef_q[IDX_A2] <= RST_A2;
    end else if (wr_en) begin
      case (idx)
        IDX_B0:  coef_q[IDX_B0] <= pwdata[COEF_BITS-1:0];
        IDX_B1:  coef_q[IDX_B1] <= pwdata[COEF_BITS-1:0];
        IDX_B2:  coef_q[IDX_B2] <= pwdata[COEF_BITS-1:0];
        IDX_A1:  coef_q[IDX_A1] <= pwdata[COEF_BITS-1:0];
        IDX_A2:  coef_q[IDX_A2] <= pwdata[COEF_BITS-1:0];
        default: ;  // drop writes outside the map
      endcase
    end
  end

  always_comb begin
    case (idx)
      IDX_B0:  prdata = APB_DATA_BITS'(coef_q[IDX_B0]);
      IDX_B1:  prdata = APB_DATA_BITS'(coef_q[IDX_B1]);
      IDX_B2:  prdata = APB_DATA_BITS'(coef_q[IDX_B2]);
      IDX_A1:  prdata = APB_DATA_BITS'(coef_q[IDX_A1]);
      IDX_A2:  prdata = APB_DATA_BITS'(coef_q[IDX_A2]);
      default: prdata = '0;
    endcase
  end

  assign coef_o = coef_q;

endmodule

### rtl/biquad_transposed_df2.sv
// Biquad IIR filter, transposed direct form II, bit-serial multipliers.
// Result path: a result becomes valid after the x pass, S_SUM and S_SAT, where it waits for a free output register.
// A new sample is taken only in S_IDLE, after both passes of the multiplier bit, over the
// sample and over the fed-back output, and the update of the partial sums.
// Reset: asynchronous, active low; partial sums clear, coefficients load 1,-2,1,-0.2,0.17.
module biquad_transposed_df2
  import bq_pkg::*;
#(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  bq_in_if.sink                    samp_in_i,
  bq_out_if.source                 samp_out_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int COEF_BITS = COEF_FRAC_BITS + COEF_INT_BITS;
  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
  // Two guard bits above a full product keep the partial sums from wrapping
  localparam int ACC_BITS  = PROD_BITS + 2;
  localparam int YW_BITS   = ACC_BITS - COEF_FRAC_BITS;
  localparam int CNT_BITS  = $clog2(SAMPLE_BITS);

  localparam logic [CNT_BITS-1:0]       CNT_LAST = CNT_BITS'(SAMPLE_BITS - 1);
  localparam logic signed [ACC_BITS-1:0] HALF    = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [YW_BITS-1:0]  Y_MAX   =
    YW_BITS'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [YW_BITS-1:0]  Y_MIN   = ~Y_MAX;

  // Sequencer: multiply x by b0/b1/b2, form y, multiply y by a1/a2, update sums
  typedef enum logic [2:0] {
    S_IDLE,
    S_MULX,
    S_SUM,
    S_SAT,
    S_MULY,
    S_UPD
  } state_e;

  state_e state_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic                out_valid_q;
  logic signed [ACC_BITS-1:0] s1_q, s2_q;

  // Payload registers
  logic        [SAMPLE_BITS-1:0] mplr_q;
  logic signed [ACC_BITS-1:0]    acc_q, t1_q, t2_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic                          out_clip_q;

  logic signed [COEF_BITS-1:0] coef [NUM_COEFS];
  logic signed [COEF_BITS-1:0] mcand0, mcand1;
  logic signed [PROD_BITS-1:0] prod0, prod1, prod2;
  mul_ctrl_t                   mul_ctrl;

  logic                          in_acc;
  logic                          out_acc;
  logic                          out_free;
  logic                          sat_go;
  logic                          last_bit;
  logic signed [ACC_BITS-1:0]    rnd;
  logic signed [YW_BITS-1:0]     y_full;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic                          y_clip;

  // ---------------------------------------------------------------------------
  // Coefficient registers
  // ---------------------------------------------------------------------------
  bq_coef_regs #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_coef_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .coef_o (coef)
  );

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign samp_in_i.ready = (state_q == S_IDLE);
  assign in_acc          = samp_in_i.valid && samp_in_i.ready;
  assign out_acc         = samp_out_o.valid && samp_out_o.ready;
  // The output register frees up in the same cycle its request is taken
  assign out_free        = !out_valid_q || samp_out_o.ready;
  assign sat_go          = (state_q == S_SAT) && out_free;
  assign last_bit        = (cnt_q == CNT_LAST);

  assign samp_out_o.valid      = out_valid_q;
  assign samp_out_o.sample_out = out_sample_q;
  assign samp_out_o.clipped    = out_clip_q;

  // ---------------------------------------------------------------------------
  // Multiplier lanes. All three share the serial multiplier bit, LSB first.
  // Lanes 0 and 1 take b0/b1 in the x pass and a1/a2 in the y pass; lane 2
  // takes b2 and its product is used only from the x pass.
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_ctrl.load = in_acc || sat_go;
    mul_ctrl.step = (state_q == S_MULX) || (state_q == S_MULY);
    mul_ctrl.last = last_bit;
  end

  assign mcand0 = (state_q == S_MULY) ? coef[IDX_A1] : coef[IDX_B0];
  assign mcand1 = (state_q == S_MULY) ? coef[IDX_A2] : coef[IDX_B1];

  bq_ser_mul #(
    .MCAND_BITS(COEF_BITS),
    .MPLR_BITS (SAMPLE_BITS)
  ) u_mul0 (
    .clk_i     (clk_i),
    .ctrl_i    (mul_ctrl),
    .mcand_i   (mcand0),
    .mplr_bit_i(mplr_q[0]),
    .prod_o    (prod0)
  );

  bq_ser_mul #(
    .MCAND_BITS(COEF_BITS),
    .MPLR_BITS (SAMPLE_BITS)
  ) u_mul1 (
    .clk_i     (clk_i),
    .ctrl_i    (mul_ctrl),
    .mcand_i   (mcand1),
    .mplr_bit_i(mplr_q[0]),
    .prod_o    (prod1)
  );

  bq_ser_mul #(
    .MCAND_BITS(COEF_BITS),
    .MPLR_BITS (SAMPLE_BITS)
  ) u_mul2 (
    .clk_i     (clk_i),
    .ctrl_i    (mul_ctrl),
    .mcand_i   (coef[IDX_B2]),
    .mplr_bit_i(mplr_q[0]),
    .prod_o    (prod2)
  );

  // ---------------------------------------------------------------------------
  // Rounding and saturation: add half an LSB, floor-shift, clamp to range
  // ---------------------------------------------------------------------------
  always_comb begin
    rnd    = acc_q + HALF;
    y_full = rnd[ACC_BITS-1:COEF_FRAC_BITS];
    y_sat  = y_full[SAMPLE_BITS-1:0];
    y_clip = 1'b0;
    if (y_full > Y_MAX) begin
      y_sat  = Y_MAX[SAMPLE_BITS-1:0];
      y_clip = 1'b1;
    end else if (y_full < Y_MIN) begin
      y_sat  = Y_MIN[SAMPLE_BITS-1:0];
      y_clip = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer, partial sums and output valid
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      s1_q        <= '0;
      s2_q        <= '0;
    end else begin
      // Drop valid once taken, unless a new result moves in at the same edge
      if (out_acc && !sat_go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cnt_q   <= '0;
            state_q <= S_MULX;
          end
        end
        S_MULX: begin
          cnt_q <= cnt_q + 1'b1;
          if (last_bit) begin
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          state_q <= S_SAT;
        end
        S_SAT: begin
          // Hold here until the previous result has left the output register
          if (sat_go) begin
            out_valid_q <= 1'b1;
            cnt_q       <= '0;
            state_q     <= S_MULY;
          end
        end
        S_MULY: begin
          cnt_q <= cnt_q + 1'b1;
          if (last_bit) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          s1_q    <= t1_q - ACC_BITS'(prod0);
          s2_q    <= t2_q - ACC_BITS'(prod1);
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mplr_q <= samp_in_i.sample_in;
    end else if (sat_go) begin
      mplr_q <= y_sat;
    end else if (mul_ctrl.step) begin
      mplr_q <= mplr_q >> 1;
    end

    if (state_q == S_SUM) begin
      acc_q <= ACC_BITS'(prod0) + s1_q;
      t1_q  <= ACC_BITS'(prod1) + s2_q;
      t2_q  <= ACC_BITS'(prod2);
    end

    if (sat_go) begin
      out_sample_q <= y_sat;
      out_clip_q   <= y_clip;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_starts_x_pass : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_MULX) && (cnt_q == '0)
  ) else $error("accepted request did not start the x pass");

  a_result_after_sat : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_SAT)
  ) else $error("result raised outside the saturation step");

  a_clip_at_rail : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_clip_q) |->
      (out_sample_q == Y_MAX[SAMPLE_BITS-1:0]) || (out_sample_q == Y_MIN[SAMPLE_BITS-1:0])
  ) else $error("clip flag set on a sample that is not at a rail");

  a_pass_ends_on_last_bit : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_MULX) || (state_q == S_MULY)) && last_bit |=>
      (state_q == S_SUM) || (state_q == S_UPD)
  ) else $error("multiplier pass did not end after the sign bit");

endmodule
